FILE: rtl/qbd_pkg.sv
// ----------------------------------------------------------------------------
// qbd_pkg
// shared types, format codes and float constants of the block dequantizer
// ----------------------------------------------------------------------------
package qbd_pkg;

    localparam logic [1:0] FMT_Q4_F32  = 2'd0;
    localparam logic [1:0] FMT_Q4_F16  = 2'd1;
    localparam logic [1:0] FMT_Q8_F16  = 2'd2;
    localparam logic [1:0] FMT_PASS    = 2'd3;

    localparam logic [31:0] EXP_ALL_ONES = 32'h7f80_0000;
    localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
    localparam logic [31:0] DEFAULT_NAN  = 32'hffc0_0000;

    typedef struct packed {
        logic [4:0]  element_index;
        logic [31:0] value_bits;
        logic        last_of_byte;
    } result_t;

    // widen an f16 pattern to f32 exactly
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [4:0]  e;
        logic [9:0]  m;
        logic [3:0]  lz;
        logic [9:0]  mn;
        logic [7:0]  ef;
        logic [31:0] r;
        e  = h[14:10];
        m  = h[9:0];
        lz = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (m[i])
            begin
                lz = 4'(9 - i);
            end
        end
        mn = 10'(m << (lz + 4'd1));
        ef = 8'(8'd113 - {4'd0, lz} - 8'd1);
        if (e == 5'd0)
        begin
            if (m == 10'd0)
            begin
                r = {h[15], 31'd0};
            end
            else
            begin
                r = {h[15], ef, mn, 13'd0};
            end
        end
        else if (e == 5'h1f)
        begin
            r = {h[15], 8'hff, m, 13'd0};
        end
        else
        begin
            r = {h[15], 8'({3'd0, e} + 8'd112), m, 13'd0};
        end
        return r;
    endfunction

endpackage

FILE: rtl/qbd_mul.sv
// ----------------------------------------------------------------------------
// qbd_mul
// multiplies a small signed integer by an f32 scale, round to nearest even
// ----------------------------------------------------------------------------
module qbd_mul
(
    input  logic signed [7:0] q,
    input  logic [31:0]       scale,
    output logic [31:0]       result
);

    logic               sgn;
    logic [7:0]         qm;
    logic [7:0]         ee;
    logic [23:0]        sm;
    logic [31:0]        prod;
    logic [4:0]         msb;
    logic [31:0]        norm;
    logic [31:0]        sub;
    logic               g;
    logic               st;
    logic [24:0]        rnd;
    logic signed [10:0] be;
    logic signed [10:0] be_rnd;
    logic [31:0]        mag;

    always_comb
    begin
        sgn  = q[7] ^ scale[31];
        qm   = q[7] ? 8'(-q) : 8'(q);
        ee   = (scale[30:23] == 8'd0) ? 8'd1 : scale[30:23];
        sm   = {(scale[30:23] != 8'd0), scale[22:0]};
        prod = {8'd0, sm} * {24'd0, qm};
        msb  = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (prod[i])
            begin
                msb = 5'(i);
            end
        end
        // biased exponent of the product msb
        be     = $signed({3'd0, ee}) + $signed({6'd0, msb}) - 11'sd23;
        norm   = prod << (5'd31 - msb);
        g      = norm[7];
        st     = |norm[6:0];
        rnd    = {1'b0, 1'b1, norm[30:8]} + {24'd0, g & (st | norm[8])};
        be_rnd = rnd[24] ? (be + 11'sd1) : be;
        // subnormal products are exact
        sub    = prod << (ee - 8'd1);
        if (prod == 32'd0)
        begin
            mag = 32'd0;
        end
        else if (be < 11'sd1)
        begin
            mag = {1'b0, 8'd0, sub[22:0]};
        end
        else if (be_rnd >= 11'sd255)
        begin
            mag = qbd_pkg::EXP_ALL_ONES;
        end
        else
        begin
            mag = {1'b0, be_rnd[7:0], rnd[22:0]};
        end
        if (scale[30:0] == qbd_pkg::EXP_ALL_ONES[30:0])
        begin
            mag = qbd_pkg::EXP_ALL_ONES;
        end
        if (scale[30:0] > qbd_pkg::EXP_ALL_ONES[30:0])
        begin
            result = scale | qbd_pkg::QUIET_BIT;
        end
        else if ((scale[30:0] == qbd_pkg::EXP_ALL_ONES[30:0]) && (q == 8'sd0))
        begin
            result = qbd_pkg::DEFAULT_NAN;
        end
        else
        begin
            result = {sgn, mag[30:0]};
        end
    end

endmodule

FILE: rtl/quant_block_dequantizer_top.sv
// ----------------------------------------------------------------------------
// quant_block_dequantizer_top
// streams quantized weight blocks and emits single-precision elements
// ----------------------------------------------------------------------------
// One byte is taken per cycle when the output side keeps up. A value byte of
// a 4-bit format yields two results, so the input stalls while the second one
// drains; 8-bit and passthrough formats sustain one byte per cycle. The decode
// and multiply sit between the input register and a two-entry result register.
module quant_block_dequantizer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // raw_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // element_index, value_bits, zero fill
    output logic        m_axis_tlast    // last_of_byte
);

    logic [1:0]  fmt_reg;
    logic [5:0]  pos_reg;
    logic [31:0] scale_reg;
    logic [4:0]  wcnt_reg;
    logic        in_v_reg;
    logic [7:0]  in_b_reg;
    logic [1:0]  in_fmt_reg;
    logic [5:0]  in_pos_reg;
    logic [31:0] in_scale_reg;
    logic [4:0]  in_wcnt_reg;
    logic [1:0]  ov_reg;
    qbd_pkg::result_t o0_reg;
    qbd_pkg::result_t o1_reg;

    logic [5:0]  len;
    logic [5:0]  slen;
    logic [5:0]  pos;
    logic [31:0] scale_next;
    logic        in_acc;
    logic        out_acc;
    logic        stage_go;

    always_comb
    begin
        case (fmt_reg)
            qbd_pkg::FMT_Q4_F32: begin len = 6'd20; slen = 6'd4; end
            qbd_pkg::FMT_Q4_F16: begin len = 6'd18; slen = 6'd2; end
            qbd_pkg::FMT_Q8_F16: begin len = 6'd34; slen = 6'd2; end
            default:             begin len = 6'd4;  slen = 6'd4; end
        endcase
        pos = (pos_reg >= len) ? 6'd0 : pos_reg;
        scale_next = scale_reg;
        if (pos == 6'd0)
        begin
            scale_next = {24'd0, s_axis_tdata};
        end
        else if (pos < slen)
        begin
            scale_next = scale_reg | (32'(s_axis_tdata) << {pos[1:0], 3'd0});
        end
    end

    // result stage: decode registered byte
    logic [5:0]  j;
    logic [31:0] sc;
    logic        is_scale;
    logic [31:0] v_lo;
    logic [31:0] v_hi;
    logic signed [7:0] q_lo;
    logic signed [7:0] q_hi;
    qbd_pkg::result_t r0;
    qbd_pkg::result_t r1;
    logic [1:0]  rn;

    always_comb
    begin
        j        = in_pos_reg - ((in_fmt_reg == qbd_pkg::FMT_Q4_F32 ||
                                  in_fmt_reg == qbd_pkg::FMT_PASS) ? 6'd4 : 6'd2);
        is_scale = (in_fmt_reg == qbd_pkg::FMT_Q4_F32 || in_fmt_reg == qbd_pkg::FMT_PASS)
                   ? (in_pos_reg < 6'd4) : (in_pos_reg < 6'd2);
        sc       = (in_fmt_reg == qbd_pkg::FMT_Q4_F32) ? in_scale_reg
                   : qbd_pkg::widen_half(in_scale_reg[15:0]);
        if (in_fmt_reg == qbd_pkg::FMT_Q8_F16)
        begin
            q_lo = $signed(in_b_reg);
        end
        else
        begin
            q_lo = $signed({4'd0, in_b_reg[3:0]}) - 8'sd8;
        end
        q_hi = $signed({4'd0, in_b_reg[7:4]}) - 8'sd8;
        r0 = '0;
        r1 = '0;
        rn = 2'd0;
        if (in_fmt_reg == qbd_pkg::FMT_PASS)
        begin
            r0 = '{element_index: in_wcnt_reg, value_bits: in_scale_reg, last_of_byte: 1'b1};
            rn = (in_pos_reg == 6'd3) ? 2'd1 : 2'd0;
        end
        else if (!is_scale)
        begin
            if (in_fmt_reg == qbd_pkg::FMT_Q8_F16)
            begin
                r0 = '{element_index: j[4:0], value_bits: v_lo, last_of_byte: 1'b1};
                rn = 2'd1;
            end
            else
            begin
                r0 = '{element_index: (in_fmt_reg == qbd_pkg::FMT_Q4_F32) ? 5'({j[3:0], 1'b0})
                       : j[4:0], value_bits: v_lo, last_of_byte: 1'b0};
                r1 = '{element_index: (in_fmt_reg == qbd_pkg::FMT_Q4_F32) ? 5'({j[3:0], 1'b1})
                       : 5'(j[4:0] + 5'd16), value_bits: v_hi, last_of_byte: 1'b1};
                rn = 2'd2;
            end
        end
    end

    qbd_mul u_mul_lo (.q(q_lo), .scale(sc), .result(v_lo));
    qbd_mul u_mul_hi (.q(q_hi), .scale(sc), .result(v_hi));

    assign out_acc  = m_axis_tvalid && m_axis_tready;
    // stage moves when result register will be empty
    assign stage_go = (ov_reg == 2'd0) || ((ov_reg == 2'd1) && out_acc);
    assign s_axis_tready = !in_v_reg || stage_go;
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = (ov_reg != 2'd0);
    assign m_axis_tdata  = {3'd0, o0_reg.value_bits, o0_reg.element_index};
    assign m_axis_tlast  = o0_reg.last_of_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= qbd_pkg::FMT_Q4_F16;
            pos_reg   <= 6'd0;
            scale_reg <= 32'd0;
            wcnt_reg  <= 5'd0;
            in_v_reg  <= 1'b0;
            ov_reg    <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                fmt_reg   <= cfg_wdata;
                pos_reg   <= 6'd0;
                scale_reg <= 32'd0;
                wcnt_reg  <= 5'd0;
            end
            else if (in_acc)
            begin
                scale_reg <= scale_next;
                pos_reg   <= (pos + 6'd1 >= len) ? 6'd0 : 6'(pos + 6'd1);
                if (fmt_reg == qbd_pkg::FMT_PASS && pos == 6'd3)
                begin
                    wcnt_reg <= 5'(wcnt_reg + 5'd1);
                end
            end
            if (in_v_reg && stage_go)
            begin
                ov_reg <= rn;
            end
            else if (out_acc)
            begin
                ov_reg <= 2'(ov_reg - 2'd1);
            end
            if (in_acc)
            begin
                in_v_reg <= 1'b1;
            end
            else if (stage_go)
            begin
                in_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_b_reg     <= s_axis_tdata;
            in_fmt_reg   <= fmt_reg;
            in_pos_reg   <= pos;
            in_scale_reg <= scale_next;
            in_wcnt_reg  <= wcnt_reg;
        end
        if (in_v_reg && stage_go)
        begin
            o0_reg <= r0;
            o1_reg <= r1;
        end
        else if (out_acc)
        begin
            o0_reg <= o1_reg;
        end
    end

    a_ov_range: assert property (@(posedge clk) disable iff (!rst_n) ov_reg != 2'd3)
        else $error("result count out of range");
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n) pos_reg < 6'd34)
        else $error("byte position out of range");
    a_two_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg == 2'd2) |-> (!o0_reg.last_of_byte && o1_reg.last_of_byte))
        else $error("pair tagging wrong");

endmodule
